// File: rtl/ctcc_pkg.sv
// Shared types, codes and constants of the current/torque curve converter.
package ctcc_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int SRCH_W     = IDX_W + 2;

	localparam int VAL_W      = 32;
	localparam int COL_W      = 31;
	localparam int PROD_W     = 2 * COL_W;
	localparam int DIV_BITS   = 2;
	localparam int DIV_STEPS  = PROD_W / DIV_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int SUM_W      = 64;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_I2T  = 2'd1;
	localparam logic [1:0] KIND_T2I  = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam logic signed [VAL_W-1:0] RES_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] RES_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [1:0]              kind;
		logic [IDX_W-1:0]        point_index;
		logic [COL_W-1:0]        point_current;
		logic [COL_W-1:0]        point_torque;
		logic signed [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] result;
		logic                    saturated;
	} out_item_t;

	typedef struct packed {
		logic [COL_W-1:0] current;
		logic [COL_W-1:0] torque;
	} point_t;

	typedef struct packed {
		logic             capture;
		logic             wr;
		logic [IDX_W-1:0] rd_addr_a;
		logic [IDX_W-1:0] rd_addr_b;
		logic             seg_load;
		logic             mul;
		logic             div_start;
		logic             sum_clr;
		logic             sum_en;
		logic             use_q;
		logic             out_load;
	} ctcc_cmd_t;

	typedef struct packed {
		logic x_le_a;
		logic x_lt_a;
		logic x_ge_b;
		logic x_le_b;
		logic dx_zero;
		logic div_done;
		logic out_free;
	} ctcc_stat_t;

endpackage

// File: rtl/ctcc_table.sv
// Calibration point memory: one write port, two registered read ports.
module ctcc_table import ctcc_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  point_t           wdata,
	input  logic [IDX_W-1:0] raddr_a,
	input  logic [IDX_W-1:0] raddr_b,
	output point_t           rdata_a,
	output point_t           rdata_b
);

	point_t mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: rtl/ctcc_divider.sv
// Unsigned restoring divider, two quotient bits per cycle.
module ctcc_divider import ctcc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [COL_W-1:0]  divisor,
	output logic              done,
	output logic [PROD_W-1:0] quotient
);

	logic [COL_W-1:0]     rem_q;
	logic [PROD_W-1:0]    quo_q;
	logic [COL_W-1:0]     div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [COL_W-1:0]     rem_d;
	logic [PROD_W-1:0]    quo_d;
	logic [COL_W:0]       trial;

	always_comb begin
		rem_d = rem_q;
		quo_d = quo_q;
		trial = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial = {rem_d, quo_d[PROD_W-1]};
			quo_d = {quo_d[PROD_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				trial    = trial - {1'b0, div_q};
				quo_d[0] = 1'b1;
			end
			rem_d = trial[COL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/ctcc_datapath.sv
// Datapath: input capture, table, segment math, divider, sum and output register.
module ctcc_datapath import ctcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_data,
	input  ctcc_cmd_t  cmd,
	output ctcc_stat_t stat,
	input  logic       out_stall,
	output logic       out_valid,
	output out_item_t  out_data
);

	logic [VAL_W-1:0]         x_q;
	logic                     neg_q;
	logic                     dir_q;
	point_t                   wr_point;
	point_t                   rd_a;
	point_t                   rd_b;
	logic [COL_W-1:0]         a_in;
	logic [COL_W-1:0]         b_in;
	logic [COL_W-1:0]         a0_q, a1_q, b0_q, b1_q;
	logic signed [VAL_W:0]    dxm;
	logic signed [VAL_W-1:0]  dy;
	logic signed [VAL_W-1:0]  dx;
	logic [VAL_W-1:0]         dxm_mag;
	logic [COL_W-1:0]         dy_mag;
	logic [COL_W-1:0]         dx_mag;
	logic [PROD_W:0]          prod_full;
	logic [PROD_W-1:0]        prod_q;
	logic                     qneg_q;
	logic [PROD_W-1:0]        quo;
	logic                     div_done;
	logic signed [SUM_W-1:0]  b0_ext, q_ext, term_b, term_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     fits;
	out_item_t                res;
	logic                     out_valid_q;
	out_item_t                out_data_q;
	logic                     out_free;

	// capture magnitude and sign; -2^31 becomes 2^31 unsigned
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dir_q <= (in_data.kind == KIND_T2I);
			neg_q <= in_data.value[VAL_W-1];
			x_q   <= in_data.value[VAL_W-1] ? VAL_W'(-in_data.value) : in_data.value;
		end
	end

	assign wr_point.current = in_data.point_current;
	assign wr_point.torque  = in_data.point_torque;

	ctcc_table u_table (
		.clk     (clk),
		.we      (cmd.wr),
		.waddr   (in_data.point_index),
		.wdata   (wr_point),
		.raddr_a (cmd.rd_addr_a),
		.raddr_b (cmd.rd_addr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	assign a_in = dir_q ? rd_a.torque : rd_a.current;
	assign b_in = dir_q ? rd_b.torque : rd_b.current;

	always_ff @(posedge clk) begin
		if (cmd.seg_load) begin
			a0_q <= a_in;
			a1_q <= b_in;
			b0_q <= dir_q ? rd_a.current : rd_a.torque;
			b1_q <= dir_q ? rd_b.current : rd_b.torque;
		end
	end

	assign dxm = $signed({1'b0, x_q}) - $signed({2'b0, a0_q});
	assign dy  = $signed({1'b0, b1_q}) - $signed({1'b0, b0_q});
	assign dx  = $signed({1'b0, a1_q}) - $signed({1'b0, a0_q});

	assign dxm_mag = dxm[VAL_W] ? VAL_W'(-dxm) : dxm[VAL_W-1:0];
	assign dy_mag  = dy[VAL_W-1] ? COL_W'(-dy) : dy[COL_W-1:0];
	assign dx_mag  = dx[VAL_W-1] ? COL_W'(-dx) : dx[COL_W-1:0];

	assign prod_full = {{(PROD_W+1-VAL_W){1'b0}}, dxm_mag} *
	                   {{(PROD_W+1-COL_W){1'b0}}, dy_mag};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= prod_full[PROD_W-1:0];
			qneg_q <= dxm[VAL_W] ^ dy[VAL_W-1] ^ dx[VAL_W-1];
		end
	end

	ctcc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (dx_mag),
		.done     (div_done),
		.quotient (quo)
	);

	// signed result = +-b0 +- quotient, sign of input folded into both terms
	assign b0_ext = $signed({{(SUM_W-COL_W){1'b0}}, b0_q});
	assign q_ext  = $signed({{(SUM_W-PROD_W){1'b0}}, quo});
	assign term_b = neg_q ? -b0_ext : b0_ext;
	assign term_q = !cmd.use_q ? '0 : ((qneg_q ^ neg_q) ? -q_ext : q_ext);

	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (cmd.sum_en) begin
			sum_q <= term_b + term_q;
		end
	end

	assign fits = (sum_q[SUM_W-1:VAL_W-1] == '0) || (sum_q[SUM_W-1:VAL_W-1] == '1);
	assign res.result    = fits ? sum_q[VAL_W-1:0] : (sum_q[SUM_W-1] ? RES_MIN : RES_MAX);
	assign res.saturated = !fits;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= res;
		end
	end

	assign stat.x_le_a   = x_q <= {1'b0, a_in};
	assign stat.x_lt_a   = x_q <  {1'b0, a_in};
	assign stat.x_ge_b   = x_q >= {1'b0, b_in};
	assign stat.x_le_b   = x_q <= {1'b0, b_in};
	assign stat.dx_zero  = (a0_q == a1_q);
	assign stat.div_done = div_done;
	assign stat.out_free = out_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while held");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.dx_zero)
		else $error("divider started on zero-width segment");

	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.saturated) |->
		(out_data_q.result == RES_MAX || out_data_q.result == RES_MIN))
		else $error("saturated flag without clamped result");

endmodule

// File: rtl/ctcc_ctrl.sv
// Controller: request sequencing, end checks, binary search and segment selection.
module ctcc_ctrl import ctcc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       in_kind,
	output logic             in_stall,
	input  logic             cfg_valid,
	input  logic [CNT_W-1:0] cfg_data,
	output logic             cfg_ready,
	input  ctcc_stat_t       stat,
	output ctcc_cmd_t        cmd
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_ZERO    = 4'd1;
	localparam logic [3:0] ST_ENDS_RD = 4'd2;
	localparam logic [3:0] ST_ENDS    = 4'd3;
	localparam logic [3:0] ST_SRCH_RD = 4'd4;
	localparam logic [3:0] ST_SRCH    = 4'd5;
	localparam logic [3:0] ST_SEG_RD  = 4'd6;
	localparam logic [3:0] ST_SEG     = 4'd7;
	localparam logic [3:0] ST_MUL     = 4'd8;
	localparam logic [3:0] ST_DIVGO   = 4'd9;
	localparam logic [3:0] ST_DIV     = 4'd10;
	localparam logic [3:0] ST_OUT     = 4'd11;

	logic [3:0]               state_q, state_d;
	logic [CNT_W-1:0]         pc_q;
	logic [CNT_W-1:0]         n_eff, n_m1, n_m2;
	logic signed [SRCH_W-1:0] lo_q, lo_d, hi_q, hi_d, mid_sum;
	logic [IDX_W-1:0]         mid_q, mid_d, mid_c;
	logic [IDX_W-1:0]         seg_a_q, seg_a_d, seg_b_q, seg_b_d;

	assign n_eff   = (pc_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : pc_q;
	assign n_m1    = n_eff - CNT_W'(1);
	assign n_m2    = n_eff - CNT_W'(2);
	assign mid_sum = lo_q + hi_q;
	assign mid_c   = mid_sum[IDX_W:1];

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		mid_d   = mid_q;
		seg_a_d = seg_a_q;
		seg_b_d = seg_b_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (in_kind)
						KIND_LOAD: cmd.wr = 1'b1;
						KIND_I2T, KIND_T2I: begin
							cmd.capture = 1'b1;
							state_d     = (n_eff < CNT_W'(2)) ? ST_ZERO : ST_ENDS_RD;
						end
						default: ;
					endcase
				end
			end
			ST_ZERO: begin
				cmd.sum_clr = 1'b1;
				state_d     = ST_OUT;
			end
			ST_ENDS_RD: begin
				cmd.rd_addr_a = '0;
				cmd.rd_addr_b = n_m1[IDX_W-1:0];
				state_d       = ST_ENDS;
			end
			ST_ENDS: begin
				priority if (stat.x_le_a) begin
					seg_a_d = '0;
					seg_b_d = '0;
					state_d = ST_SEG_RD;
				end else if (stat.x_ge_b) begin
					seg_a_d = n_m2[IDX_W-1:0];
					seg_b_d = n_m1[IDX_W-1:0];
					state_d = ST_SEG_RD;
				end else begin
					lo_d    = '0;
					hi_d    = $signed({{(SRCH_W-CNT_W){1'b0}}, n_m2});
					state_d = ST_SRCH_RD;
				end
			end
			ST_SRCH_RD: begin
				if (lo_q <= hi_q) begin
					mid_d         = mid_c;
					cmd.rd_addr_a = mid_c;
					cmd.rd_addr_b = mid_c + IDX_W'(1);
					state_d       = ST_SRCH;
				end else begin
					seg_a_d = '0;
					seg_b_d = IDX_W'(1);
					state_d = ST_SEG_RD;
				end
			end
			ST_SRCH: begin
				priority if (!stat.x_lt_a && stat.x_le_b) begin
					seg_a_d = mid_q;
					seg_b_d = mid_q + IDX_W'(1);
					state_d = ST_SEG_RD;
				end else if (stat.x_lt_a) begin
					hi_d    = $signed({2'b0, mid_q}) - SRCH_W'(1);
					state_d = ST_SRCH_RD;
				end else begin
					lo_d    = $signed({2'b0, mid_q}) + SRCH_W'(1);
					state_d = ST_SRCH_RD;
				end
			end
			ST_SEG_RD: begin
				cmd.rd_addr_a = seg_a_q;
				cmd.rd_addr_b = seg_b_q;
				state_d       = ST_SEG;
			end
			ST_SEG: begin
				cmd.seg_load = 1'b1;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				if (stat.dx_zero) begin
					cmd.sum_en = 1'b1;
					state_d    = ST_OUT;
				end else begin
					cmd.mul = 1'b1;
					state_d = ST_DIVGO;
				end
			end
			ST_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) begin
					cmd.sum_en = 1'b1;
					cmd.use_q  = 1'b1;
					state_d    = ST_OUT;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			mid_q   <= '0;
			seg_a_q <= '0;
			seg_b_q <= '0;
		end else begin
			state_q <= state_d;
			lo_q    <= lo_d;
			hi_q    <= hi_d;
			mid_q   <= mid_d;
			seg_a_q <= seg_a_d;
			seg_b_q <= seg_b_d;
			if (cfg_valid && cfg_ready) begin
				pc_q <= cfg_data;
			end
		end
	end

	a_srch_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> ({1'b0, mid_q} < n_m1))
		else $error("search midpoint outside valid segments");

	a_conv_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (in_kind == KIND_I2T || in_kind == KIND_T2I))
		|=> in_stall)
		else $error("convert request did not hold off input");

	a_out_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> !in_stall)
		else $error("input not reopened after result handoff");

endmodule

// File: rtl/current_torque_curve_converter_unit.sv
// Current/torque curve converter: top level joining controller and datapath.
// Loads give no result. Converts with point_count < 2 skip the table walk; others run
//   the end check and binary search, and a flat segment skips multiply and divide.
// Flow: one request at a time; the next is accepted in the cycle after the result is
//   loaded, and that load waits while an earlier result is still held.
// Reset (arst_n low, async): point_count 0, controller idle, no result pending; table kept.
module current_torque_curve_converter_unit import ctcc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// request channel
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	// result channel
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	// point_count register write
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	// Controller and datapath talk only through these two bundles.
	ctcc_cmd_t  cmd;
	ctcc_stat_t stat;

	// Controller: accepts requests in idle only. Loads are written to the table the same cycle;
	// converts (with point_count >= 2) walk end check, binary search (two table reads per probe),
	// segment fetch, multiply and serial divide (skipped on a flat segment), then result handoff.
	ctcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_kind   (in_data.kind),
		.in_stall  (in_stall),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: dual-read point table, Q16.16 interpolation
	// b0 + (x - a0) * (b1 - b0) / (a1 - a0) in sign-magnitude form with a
	// truncating divider, sign restore and 32-bit clamp. The result register
	// lets the controller go back to idle while a result still waits.
	ctcc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the current/torque curve converter: directed table, then random phases.
module testbench import ctcc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// settle time after the last result before touching point_count or ending;
	// loads give no result at all
	localparam int SETTLE_CYCLES = 120;
	// cycles without any handshake before the run is declared hung
	localparam int QUIET_LIMIT   = 3000;
	localparam int ITEM_TARGET   = 700;
	localparam int PRINT_CAP     = 40;

	typedef enum logic {ROW_REQ, ROW_CFG} row_op_e;
	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

	// one line of the directed table; typed rows carry their expected result
	typedef struct packed {
		row_op_e                 op;
		logic [1:0]              kind;
		logic [IDX_W-1:0]        index;
		logic [COL_W-1:0]        cur;
		logic [COL_W-1:0]        trq;
		logic [VAL_W-1:0]        value;
		logic [CNT_W-1:0]        count;
		bit                      typed;
		logic [VAL_W-1:0]        want_result;
		bit                      want_sat;
	} check_row_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	in_item_t         in_data   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data  = '0;

	// shadow of the calibration table and of point_count
	logic [COL_W-1:0] curve_current [MAX_POINTS];
	logic [COL_W-1:0] curve_torque  [MAX_POINTS];
	int               point_count_shadow = 0;

	// converted values still owed by the block, oldest first
	out_item_t        pending_results [$];
	out_item_t        oldest_result;

	int mismatch_count = 0;
	int load_count     = 0;
	int convert_count  = 0;
	int ignored_count  = 0;
	int cfg_writes     = 0;
	int sat_seen       = 0;
	int quiet_cycles   = 0;
	int burst_left     = 0;
	bit steady_phase   = 1'b0;

	stall_mode_e stall_mode      = STALL_NONE;
	int          stall_mode_left = 0;
	int          stall_tick      = 0;

	// directed table: empty table, count below two, small hand-made curve with a
	// zero-width last segment, sign handling, saturation both ways, unordered table
	check_row_t directed_rows [] = '{
		'{ROW_REQ, KIND_I2T,  6'd0, 31'h0,       31'h0,       32'h7FFF_FFFF, 7'd0, 1'b1, 32'h0, 1'b0},
		'{ROW_REQ, KIND_T2I,  6'd0, 31'h0,       31'h0,       32'h8000_0000, 7'd0, 1'b1, 32'h0, 1'b0},
		'{ROW_REQ, KIND_NONE, 6'd63, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h1,    7'd0, 1'b0, 32'h0, 1'b0},
		'{ROW_REQ, KIND_LOAD, 6'd0, 31'h0,       31'h0,       32'h0,         7'd0, 1'b0, 32'h0, 1'b0},
		'{ROW_CFG, KIND_NONE, 6'd0, 31'h0,       31'h0,       32'h0,         7'd1, 1'b0, 32'h0, 1'b0},
		'{ROW_REQ, KIND_I2T,  6'd0, 31'h0,       31'h0,       32'h0001_2345, 7'd0, 1'b1, 32'h0, 1'b0},
		'{ROW_REQ, KIND_LOAD, 6'd1, 31'h1_0000,  31'h2_0000,  32'h0,         7'd0, 1'b0, 32'h0, 1'b0},
		'{ROW_REQ, KIND_LOAD, 6'd2, 31'h3_0000,  31'h5_0000,  32'h0,         7'd0, 1'b0, 32'h0, 1'b0},
		'{ROW_REQ, KIND_LOAD, 6'd3, 31'h3_0000,  31'h6_0000,  32'h0,         7'd0, 1'b0, 32'h0, 1'b0},
		'{ROW_CFG, KIND_NONE, 6'd0, 31'h0,       31'h0,       32'h0,         7'd4, 1'b0, 32'h0, 1'b0},
		'{ROW_REQ, KIND_I2T,  6'd0, 31'h0,       31'h0,       32'h0,         7'd0, 1'b1, 32'h0, 1'b0},
		'{ROW_REQ, KIND_I2T,  6'd0, 31'h0,       31'h0,       32'h0000_8000, 7'd0, 1'b1,
			32'h0001_0000, 1'b0},
		'{ROW_REQ, KIND_I2T,  6'd0, 31'h0,       31'h0,       32'hFFFF_8000, 7'd0, 1'b1,
			32'hFFFF_0000, 1'b0},
		'{ROW_REQ, KIND_I2T,  6'd0, 31'h0,       31'h0,       32'h7FFF_FFFF, 7'd0, 1'b0, 32'h0, 1'b0},
		'{ROW_REQ, KIND_T2I,  6'd0, 31'h0,       31'h0,       32'h0004_0000, 7'd0, 1'b0, 32'h0, 1'b0},
		'{ROW_REQ, KIND_T2I,  6'd0, 31'h0,       31'h0,       32'h8000_0000, 7'd0, 1'b0, 32'h0, 1'b0},
		'{ROW_REQ, KIND_LOAD, 6'd4, 31'h4_0000,  31'h7FFF_FFFF, 32'h0,       7'd0, 1'b0, 32'h0, 1'b0},
		'{ROW_CFG, KIND_NONE, 6'd0, 31'h0,       31'h0,       32'h0,         7'd5, 1'b0, 32'h0, 1'b0},
		'{ROW_REQ, KIND_I2T,  6'd0, 31'h0,       31'h0,       32'h7FFF_FFFF, 7'd0, 1'b1,
			32'h7FFF_FFFF, 1'b1},
		'{ROW_REQ, KIND_I2T,  6'd0, 31'h0,       31'h0,       32'h8000_0000, 7'd0, 1'b1,
			32'h8000_0000, 1'b1},
		'{ROW_REQ, KIND_T2I,  6'd0, 31'h0,       31'h0,       32'h7FFF_FFFF, 7'd0, 1'b0, 32'h0, 1'b0},
		'{ROW_REQ, KIND_LOAD, 6'd1, 31'h5_0000,  31'h1000,    32'h0,         7'd0, 1'b0, 32'h0, 1'b0},
		'{ROW_REQ, KIND_I2T,  6'd0, 31'h0,       31'h0,       32'h0002_0000, 7'd0, 1'b0, 32'h0, 1'b0},
		'{ROW_REQ, KIND_T2I,  6'd0, 31'h0,       31'h0,       32'h0000_0800, 7'd0, 1'b0, 32'h0, 1'b0}
	};

	current_torque_curve_converter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor
	// dir t2i picks the torque column as input and the current column as output
	function automatic longint column_in(int i, bit t2i);
		return t2i ? longint'(curve_torque[i]) : longint'(curve_current[i]);
	endfunction

	function automatic longint column_out(int i, bit t2i);
		return t2i ? longint'(curve_current[i]) : longint'(curve_torque[i]);
	endfunction

	// straight line through two points; a zero-width segment is flat
	function automatic longint segment_value(int i0, int i1, longint x, bit t2i);
		longint a0, a1, b0, b1;
		a0 = column_in(i0, t2i);
		a1 = column_in(i1, t2i);
		b0 = column_out(i0, t2i);
		b1 = column_out(i1, t2i);
		if (a1 == a0)
			return b0;
		return b0 + ((x - a0) * (b1 - b0)) / (a1 - a0);
	endfunction

	// clamp below point 0, extrapolate past the last point, else binary search;
	// an unordered table that defeats the search falls back to segment 0
	function automatic longint curve_lookup(longint x, int n, bit t2i);
		int lo, hi, mid, seg;
		if (x <= column_in(0, t2i))
			return column_out(0, t2i);
		if (x >= column_in(n - 1, t2i))
			return segment_value(n - 2, n - 1, x, t2i);
		lo  = 0;
		hi  = n - 2;
		seg = 0;
		while (lo <= hi) begin
			mid = (lo + hi) >>> 1;
			if (x >= column_in(mid, t2i) && x <= column_in(mid + 1, t2i)) begin
				seg = mid;
				break;
			end
			if (x < column_in(mid, t2i))
				hi = mid - 1;
			else
				lo = mid + 1;
		end
		return segment_value(seg, seg + 1, x, t2i);
	endfunction

	function automatic out_item_t predict_conversion(in_item_t req);
		out_item_t res;
		longint    mag, r;
		int        n;
		res = '0;
		n = (point_count_shadow > MAX_POINTS) ? MAX_POINTS : point_count_shadow;
		if (n >= 2) begin
			// magnitude of -2^31 is 2^31, fine in 64 bits
			mag = longint'(req.value);
			if (mag < 0)
				mag = -mag;
			r = curve_lookup(mag, n, req.kind == KIND_T2I);
			if (req.value < 0)
				r = -r;
			if (r > longint'(RES_MAX)) begin
				res.result    = RES_MAX;
				res.saturated = 1'b1;
			end else if (r < longint'(RES_MIN)) begin
				res.result    = RES_MIN;
				res.saturated = 1'b1;
			end else begin
				res.result = r[VAL_W-1:0];
			end
		end
		return res;
	endfunction

	// ---------------------------------------------------------------- checking
	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t ns mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %h sat %b with nothing outstanding",
					out_data.result, out_data.saturated));
			end else begin
				oldest_result = pending_results.pop_front();
				if (out_data.result !== oldest_result.result)
					report_mismatch($sformatf("result %h, want %h",
						out_data.result, oldest_result.result));
				if (out_data.saturated !== oldest_result.saturated)
					report_mismatch($sformatf("saturated %b, want %b (result %h)",
						out_data.saturated, oldest_result.saturated, oldest_result.result));
				if (oldest_result.saturated)
					sat_seen++;
			end
		end
	end

	// hang detector: any handshake on any channel resets the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: %0d cycles without a handshake, %0d results outstanding",
					quiet_cycles, pending_results.size());
				$display("[current_torque_curve_converter_unit] ERROR");
				$finish;
			end
		end
	end

	// result backpressure: random modes, one of which never stalls so that
	// results also get through without any backpressure
	always @(negedge clk) begin
		if (stall_mode_left == 0) begin
			stall_mode      = stall_mode_e'($urandom_range(0, 3));
			stall_mode_left = $urandom_range(50, 400);
		end else begin
			stall_mode_left--;
		end
		stall_tick++;
		unique case (stall_mode)
			STALL_NONE:   out_stall <= 1'b0;
			STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
			default:      out_stall <= ((stall_tick % 9) < 4);
		endcase
	end

	// ---------------------------------------------------------------- driving
	// present one request at the falling edge, hold it until accepted; the
	// sender runs in bursts with idle gaps unless the phase is a steady one
	task automatic send_request(in_item_t req, bit typed, out_item_t typed_res);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (steady_phase || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// accepted at this edge: update the shadow table or queue the answer
		unique case (req.kind)
			KIND_LOAD: begin
				curve_current[req.point_index] = req.point_current;
				curve_torque[req.point_index]  = req.point_torque;
				load_count++;
			end
			KIND_I2T, KIND_T2I: begin
				pending_results.push_back(typed ? typed_res : predict_conversion(req));
				convert_count++;
			end
			default: ignored_count++;
		endcase
	endtask

	// drop valid, let every owed result come out, then give a trailing load
	// time to finish inside the block
	task automatic drain_and_settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_point_count(logic [CNT_W-1:0] count);
		drain_and_settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= count;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		point_count_shadow = int'(count);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------- stimulus
	function automatic in_item_t random_request(logic [1:0] kind);
		in_item_t req;
		req.kind          = kind;
		req.point_index   = IDX_W'($urandom);
		req.point_current = COL_W'($urandom);
		req.point_torque  = COL_W'($urandom);
		req.value         = $urandom;
		return req;
	endfunction

	// increment bound for an ascending column of m points that stays in 31 bits
	function automatic int unsigned pick_step(int m);
		int unsigned widest;
		widest = (32'h7FFF_FFFF - 32'h2_0000) / m;
		unique case ($urandom_range(0, 2))
			0:       return widest;
			1:       return widest / 16;
			default: return (widest < 32'h8_0000) ? widest : 32'h8_0000;
		endcase
	endfunction

	// mostly points inside or a bit past the table, some exact breakpoints,
	// some extremes and some fully random words; sign chosen at random
	function automatic logic [VAL_W-1:0] pick_value(int n, bit t2i);
		longint top, mag;
		int     pick;
		pick = $urandom_range(0, 9);
		if (n < 2 || pick == 0)
			return $urandom;
		if (pick == 1) begin
			unique case ($urandom_range(0, 4))
				0:       return 32'h7FFF_FFFF;
				1:       return 32'h8000_0000;
				2:       return 32'h0;
				3:       return 32'hFFFF_FFFF;
				default: return 32'h1;
			endcase
		end
		if (pick == 2) begin
			mag = column_in($urandom_range(0, n - 1), t2i);
		end else begin
			top = column_in(n - 1, t2i);
			top = top + top / 4 + 2;
			if (top > 64'h7FFF_FFFF)
				top = 64'h7FFF_FFFF;
			mag = longint'($urandom_range(0, 32'(top)));
		end
		if ($urandom_range(0, 1))
			mag = -mag;
		return mag[VAL_W-1:0];
	endfunction

	// fresh curve of m points loaded in shuffled order; usually ascending from
	// (0,0) with some flat steps, now and then scrambled on purpose
	task automatic load_curve(int m);
		logic [COL_W-1:0] cur_pts [MAX_POINTS];
		logic [COL_W-1:0] trq_pts [MAX_POINTS];
		int               order   [MAX_POINTS];
		int unsigned      cur_step, trq_step;
		longint           cur_acc, trq_acc;
		int               i, j, tmp;
		bit               scrambled;
		in_item_t         req;
		cur_step  = pick_step(m);
		trq_step  = pick_step(m);
		scrambled = ($urandom_range(0, 9) == 0);
		cur_acc   = 0;
		trq_acc   = 0;
		if ($urandom_range(0, 7) == 0) begin
			cur_acc = longint'($urandom_range(0, 32'h2_0000));
			trq_acc = longint'($urandom_range(0, 32'h2_0000));
		end
		for (i = 0; i < m; i++) begin
			if (scrambled) begin
				cur_pts[i] = COL_W'($urandom);
				trq_pts[i] = COL_W'($urandom);
			end else begin
				cur_pts[i] = cur_acc[COL_W-1:0];
				trq_pts[i] = trq_acc[COL_W-1:0];
				if ($urandom_range(0, 9) != 0)
					cur_acc += longint'($urandom_range(0, cur_step));
				if ($urandom_range(0, 9) != 0)
					trq_acc += longint'($urandom_range(0, trq_step));
			end
			order[i] = i;
		end
		for (i = m - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			tmp      = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (i = 0; i < m; i++) begin
			req               = random_request(KIND_LOAD);
			req.point_index   = IDX_W'(order[i]);
			req.point_current = cur_pts[order[i]];
			req.point_torque  = trq_pts[order[i]];
			send_request(req, 1'b0, '0);
		end
	endtask

	// one setting of point_count: idle write, curve load, then conversions
	// with a little noise (stray loads that may break ordering, unused kind)
	task automatic run_random_phase(logic [CNT_W-1:0] count);
		int       n, convs, pick;
		in_item_t req;
		write_point_count(count);
		steady_phase = ($urandom_range(0, 3) == 0);
		n = (count > CNT_W'(MAX_POINTS)) ? MAX_POINTS : int'(count);
		if (n >= 2)
			load_curve(n);
		convs = $urandom_range(15, 40);
		repeat (convs) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				req = random_request(KIND_LOAD);
				// stray loads land only on points already loaded when a table is live
				if (n >= 2)
					req.point_index = IDX_W'($urandom_range(0, n - 1));
			end else if (pick == 1) begin
				req = random_request(KIND_NONE);
			end else begin
				req = random_request(($urandom_range(0, 1) == 0) ? KIND_I2T : KIND_T2I);
				req.value = pick_value(n, req.kind == KIND_T2I);
			end
			send_request(req, 1'b0, '0);
		end
	endtask

	initial begin : main_sequence
		check_row_t       row;
		in_item_t         req;
		out_item_t        typed_res;
		logic [CNT_W-1:0] count;
		int               start_items, phase, sel;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table; point_count starts at its reset value of zero
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.op == ROW_CFG) begin
				write_point_count(row.count);
			end else begin
				req.kind              = row.kind;
				req.point_index       = row.index;
				req.point_current     = row.cur;
				req.point_torque      = row.trq;
				req.value             = row.value;
				typed_res.result      = row.want_result;
				typed_res.saturated   = row.want_sat;
				send_request(req, row.typed, typed_res);
			end
		end

		// random phases: the extremes of point_count first (full table, a count
		// past the table size, empty, the minimum, one point), then mostly small
		start_items = load_count + convert_count;
		phase = 0;
		while (load_count + convert_count - start_items < ITEM_TARGET) begin
			unique case (phase)
				0:       count = CNT_W'(MAX_POINTS);
				1:       count = 7'd127;
				2:       count = 7'd0;
				3:       count = 7'd2;
				4:       count = 7'd1;
				default: begin
					sel = $urandom_range(0, 19);
					if (sel < 2)
						count = CNT_W'($urandom_range(0, 1));
					else if (sel < 4)
						count = CNT_W'($urandom_range(20, MAX_POINTS));
					else if (sel == 4)
						count = CNT_W'($urandom_range(MAX_POINTS + 1, 127));
					else
						count = CNT_W'($urandom_range(2, 10));
				end
			endcase
			run_random_phase(count);
			phase++;
		end

		drain_and_settle();

		$display("covered %0d requests: %0d point loads, %0d conversions, %0d of unused kind",
			load_count + convert_count + ignored_count, load_count, convert_count, ignored_count);
		$display("%0d point_count writes, %0d clamped results, %0d mismatches",
			cfg_writes, sat_seen, mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("[current_torque_curve_converter_unit] OK");
		else
			$display("[current_torque_curve_converter_unit] ERROR");
		$finish;
	end

endmodule
